### rtl/core/sync_packet_deframer_fletcher8_core_macros.svh
// Assertion macros shared by the deframer RTL.
// No dependencies; included by modules that carry concurrent assertions.
`ifndef SYNC_PACKET_DEFRAMER_FLETCHER8_CORE_MACROS_SVH
`define SYNC_PACKET_DEFRAMER_FLETCHER8_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SPDF_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("spdf check failed");

// Next-cycle implication, checked outside reset
`define SPDF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("spdf check failed");

`endif

### rtl/core/spdf_pkg.sv
// Shared types and constants for the sync-header packet deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package spdf_pkg;

    // Configuration register indexes and reset values
    localparam logic CFG_IDX_SYNC_FIRST  = 1'b0;
    localparam logic CFG_IDX_SYNC_SECOND = 1'b1;
    localparam logic [7:0] SYNC_FIRST_RESET  = 8'd147;
    localparam logic [7:0] SYNC_SECOND_RESET = 8'd224;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Packed master tdata width (33 bits of fields, padded to whole bytes)
    localparam int M_TDATA_W = 40;

    // One result item
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [7:0] frame_id;
        logic [7:0] byte_index;
        logic [7:0] frame_length;
        logic       checksum_good;
    } spdf_result_t;

endpackage

`default_nettype wire

### rtl/core/spdf_in_stage.sv
// Input register of the deframer: holds one received byte.
// Depends on spdf_pkg.
`default_nettype none

module spdf_in_stage
    import spdf_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       take,       // byte consumed by the frame logic
    output logic            byte_valid,
    output logic [7:0]      byte_value
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // Free when empty or drained in this cycle
    assign s_tready   = !valid_reg || take;
    assign byte_valid = valid_reg;
    assign byte_value = byte_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload register, no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

endmodule

`default_nettype wire

### rtl/core/spdf_frame_fsm.sv
// Frame parser: sync hunt, header, payload streaming, Fletcher-8 check.
// Depends on spdf_pkg and the shared assertion macros header.
`default_nettype none
`include "sync_packet_deframer_fletcher8_core_macros.svh"

module spdf_frame_fsm
    import spdf_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,        // process rx_byte this cycle
    input  wire logic [7:0] rx_byte,
    input  wire logic [7:0] sync_first,
    input  wire logic [7:0] sync_second,
    output logic            res_valid,   // a result comes with this step
    output spdf_result_t    res
);

    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_SYNC2 = 3'd1;
    localparam logic [2:0] PH_ID    = 3'd2;
    localparam logic [2:0] PH_LEN   = 3'd3;
    localparam logic [2:0] PH_PAY   = 3'd4;
    localparam logic [2:0] PH_LOW   = 3'd5;
    localparam logic [2:0] PH_HIGH  = 3'd6;

    logic [2:0] phase_reg,  phase_next;
    logic [7:0] id_reg,     id_next;
    logic [7:0] len_reg,    len_next;
    logic [7:0] count_reg,  count_next;
    logic [7:0] sum_a_reg,  sum_a_next;
    logic [7:0] sum_b_reg,  sum_b_next;
    logic [7:0] low_reg,    low_next;

    logic [7:0] sum_a_add;
    logic [7:0] sum_b_add;
    logic [7:0] count_inc;

    // Running sums, both mod 256
    assign sum_a_add = sum_a_reg + rx_byte;
    assign sum_b_add = sum_b_reg + sum_a_add;
    assign count_inc = count_reg + 8'd1;

    // Next state and result for one byte
    always_comb begin
        phase_next = phase_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        count_next = count_reg;
        sum_a_next = sum_a_reg;
        sum_b_next = sum_b_reg;
        low_next   = low_reg;
        res_valid  = 1'b0;
        res.kind          = KIND_PAYLOAD;
        res.data_byte     = 8'd0;
        res.frame_id      = id_reg;
        res.byte_index    = 8'd0;
        res.frame_length  = len_reg;
        res.checksum_good = 1'b0;
        case (phase_reg)
            PH_SYNC2: begin
                // second sync test wins when both sync values are equal
                if (rx_byte == sync_second) begin
                    phase_next = PH_ID;
                end else if (rx_byte != sync_first) begin
                    phase_next = PH_HUNT;
                end
            end
            PH_ID: begin
                id_next    = rx_byte;
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_add;
                phase_next = PH_LEN;
            end
            PH_LEN: begin
                len_next   = rx_byte;
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_add;
                // empty frame goes straight to the check bytes
                phase_next = (rx_byte == 8'd0) ? PH_LOW : PH_PAY;
            end
            PH_PAY: begin
                sum_a_next = sum_a_add;
                sum_b_next = sum_b_add;
                count_next = count_inc;
                if (count_inc >= len_reg) begin
                    phase_next = PH_LOW;
                end
                res_valid      = 1'b1;
                res.data_byte  = rx_byte;
                res.byte_index = count_reg;
            end
            PH_LOW: begin
                low_next   = rx_byte;
                phase_next = PH_HIGH;
            end
            PH_HIGH: begin
                phase_next        = PH_HUNT;
                res_valid         = 1'b1;
                res.kind          = KIND_STATUS;
                res.checksum_good = (low_reg == sum_a_reg) && (rx_byte == sum_b_reg);
            end
            default: begin
                phase_next = PH_HUNT;
                if (rx_byte == sync_first) begin
                    count_next = 8'd0;
                    sum_a_next = 8'd0;
                    sum_b_next = 8'd0;
                    phase_next = PH_SYNC2;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            id_reg    <= 8'd0;
            len_reg   <= 8'd0;
            count_reg <= 8'd0;
            sum_a_reg <= 8'd0;
            sum_b_reg <= 8'd0;
            low_reg   <= 8'd0;
        end else if (step) begin
            phase_reg <= phase_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
            low_reg   <= low_next;
        end
    end

    // Results only come from payload and high check byte phases
    `SPDF_ASSERT_NOW(a_res_phase, aclk, aresetn, res_valid, (phase_reg == PH_PAY) || (phase_reg == PH_HIGH))
    // Last payload byte moves on to the low check byte
    `SPDF_ASSERT_NEXT(a_pay_end, aclk, aresetn, step && (phase_reg == PH_PAY) && (count_inc >= len_reg), phase_reg == PH_LOW)
    // Status result closes the frame
    `SPDF_ASSERT_NEXT(a_frame_close, aclk, aresetn, step && (phase_reg == PH_HIGH), phase_reg == PH_HUNT)

endmodule

`default_nettype wire

### rtl/core/spdf_out_stage.sv
// Output register of the deframer: holds one result until taken.
// Depends on spdf_pkg.
`default_nettype none

module spdf_out_stage
    import spdf_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 load,      // new result from the parser
    input  wire spdf_result_t         res,
    output logic                      free,      // can take a result this cycle
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tuser
);

    logic         valid_reg;
    logic         valid_next;
    spdf_result_t res_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tdata  = {7'd0, res_reg.checksum_good, res_reg.frame_length,
                       res_reg.byte_index, res_reg.frame_id, res_reg.data_byte};

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload register, no reset
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

### rtl/core/sync_packet_deframer_fletcher8_core.sv
// Top level of the sync-header packet deframer with Fletcher-8 check.
// Depends on spdf_pkg, spdf_in_stage, spdf_frame_fsm and spdf_out_stage.
//
//  Channel  | Dir | Handshake          | Contents
//  ---------+-----+--------------------+-----------------------------------------
//  s_       | in  | s_tvalid/s_tready  | tdata[7:0] rx_byte
//  m_       | out | m_tvalid/m_tready  | tuser kind; tdata data, id, index, length, good
//  cfg_     | in  | cfg_valid/cfg_ready| cfg_index 0 sync_first, 1 sync_second
//
// One received byte per cycle while the output register is free; a byte is held in
// the input register and its result appears in the output register the cycle after it is parsed.
// A held output result stalls the parser, which then back-pressures s_tready.
// Synchronous active-low reset returns to sync hunt with default sync values.
`default_nettype none

module sync_packet_deframer_fletcher8_core
    import spdf_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // received bytes
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,    // [7:0] rx_byte
    // results
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,    // [7:0] data_byte, [15:8] frame_id,
                                                  // [23:16] byte_index,
                                                  // [31:24] frame_length,
                                                  // [32] checksum_good, [39:33] zero
    output logic                      m_tuser,    // [0] kind
    // configuration writes
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic                 cfg_index,
    input  wire logic [7:0]           cfg_data
);

    logic         byte_valid;
    logic [7:0]   byte_value;
    logic         out_free;
    logic         step;
    logic         res_valid;
    spdf_result_t res;
    logic [7:0]   sync_first_reg;
    logic [7:0]   sync_second_reg;

    // Sync byte registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg  <= SYNC_FIRST_RESET;
            sync_second_reg <= SYNC_SECOND_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_IDX_SYNC_FIRST) begin
                sync_first_reg <= cfg_data;
            end
            if (cfg_index == CFG_IDX_SYNC_SECOND) begin
                sync_second_reg <= cfg_data;
            end
        end
    end

    // Parse a byte whenever the output register has room
    assign step = byte_valid && out_free;

    spdf_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (step),
        .byte_valid (byte_valid),
        .byte_value (byte_value)
    );

    spdf_frame_fsm u_fsm (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .rx_byte     (byte_value),
        .sync_first  (sync_first_reg),
        .sync_second (sync_second_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    spdf_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step && res_valid),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

### bench/testbench.sv
// Self-checking bench for the sync-header packet deframer with Fletcher-8 check.
// Depends on spdf_pkg and sync_packet_deframer_fletcher8_core; tracks the frame
// parser in step with each accepted byte and compares every result transaction.
`default_nettype none

module testbench
    import spdf_pkg::*;
();

    // Parser phases of the frame tracker
    typedef enum logic [2:0] {
        PH_HUNT, PH_SYNC2, PH_ID, PH_LEN, PH_PAYLOAD, PH_CHK_LO, PH_CHK_HI
    } frame_phase_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic                 cfg_index;
    logic [7:0]           cfg_data;

    // Frame tracker state, follows the block from reset
    frame_phase_t phase_now     = PH_HUNT;
    logic [7:0]   trk_first     = SYNC_FIRST_RESET;
    logic [7:0]   trk_second    = SYNC_SECOND_RESET;
    logic [7:0]   trk_id        = '0;
    logic [7:0]   trk_len       = '0;
    logic [7:0]   trk_count     = '0;
    logic [7:0]   fl_sum_a      = '0;
    logic [7:0]   fl_sum_b      = '0;
    logic [7:0]   trk_low_check = '0;
    spdf_result_t frame_results_q[$];

    // Stimulus side
    logic [7:0] tx_first  = SYNC_FIRST_RESET;
    logic [7:0] tx_second = SYNC_SECOND_RESET;
    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    int         bytes_sent  = 0;
    int         err_count   = 0;

    sync_packet_deframer_fletcher8_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop
    initial begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    function automatic void fletcher_add(input logic [7:0] b);
        fl_sum_a = fl_sum_a + b;
        fl_sum_b = fl_sum_b + fl_sum_a;
    endfunction

    // Advance the tracker by one received byte, queue any result it causes
    function automatic void deframe_byte(input logic [7:0] rx);
        spdf_result_t res;
        res = '0;
        case (phase_now)
            PH_SYNC2: begin
                if (rx == trk_second) phase_now = PH_ID;
                else if (rx != trk_first) phase_now = PH_HUNT;
            end
            PH_ID: begin
                trk_id = rx;
                fletcher_add(rx);
                phase_now = PH_LEN;
            end
            PH_LEN: begin
                trk_len = rx;
                fletcher_add(rx);
                phase_now = (rx == 8'd0) ? PH_CHK_LO : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                res.kind         = KIND_PAYLOAD;
                res.data_byte    = rx;
                res.byte_index   = trk_count;
                res.frame_id     = trk_id;
                res.frame_length = trk_len;
                fletcher_add(rx);
                trk_count = trk_count + 8'd1;
                if (trk_count >= trk_len) phase_now = PH_CHK_LO;
                frame_results_q.push_back(res);
            end
            PH_CHK_LO: begin
                trk_low_check = rx;
                phase_now = PH_CHK_HI;
            end
            PH_CHK_HI: begin
                res.kind          = KIND_STATUS;
                res.frame_id      = trk_id;
                res.frame_length  = trk_len;
                res.checksum_good = (trk_low_check == fl_sum_a) && (rx == fl_sum_b);
                phase_now = PH_HUNT;
                frame_results_q.push_back(res);
            end
            default: begin
                phase_now = PH_HUNT;
                if (rx == trk_first) begin
                    trk_count = '0;
                    fl_sum_a  = '0;
                    fl_sum_b  = '0;
                    phase_now = PH_SYNC2;
                end
            end
        endcase
    endfunction

    task automatic check_result(input spdf_result_t want);
        if (m_tuser !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, m_tuser);
            err_count++;
        end
        if (m_tdata[7:0] !== want.data_byte) begin
            $error("data_byte: expected %0d, got %0d", want.data_byte, m_tdata[7:0]);
            err_count++;
        end
        if (m_tdata[15:8] !== want.frame_id) begin
            $error("frame_id: expected %0d, got %0d", want.frame_id, m_tdata[15:8]);
            err_count++;
        end
        if (m_tdata[23:16] !== want.byte_index) begin
            $error("byte_index: expected %0d, got %0d", want.byte_index, m_tdata[23:16]);
            err_count++;
        end
        if (m_tdata[31:24] !== want.frame_length) begin
            $error("frame_length: expected %0d, got %0d", want.frame_length,
                   m_tdata[31:24]);
            err_count++;
        end
        if (m_tdata[32] !== want.checksum_good) begin
            $error("checksum_good: expected %0d, got %0d", want.checksum_good,
                   m_tdata[32]);
            err_count++;
        end
    endtask

    // Monitor: config writes, accepted bytes, result transactions
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_IDX_SYNC_FIRST) trk_first = cfg_data;
                else trk_second = cfg_data;
            end
            if (s_tvalid && s_tready) deframe_byte(s_tdata);
            if (m_tvalid && m_tready) begin
                if (frame_results_q.size() == 0) begin
                    $error("result transaction with nothing pending");
                    err_count++;
                end else begin
                    check_result(frame_results_q.pop_front());
                end
            end
        end
    end

    // One byte on the input channel, with random hold-off before it
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    // Drop valid, wait for all results, then let the pipeline empty
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (frame_results_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Program both sync bytes while the block is idle
    task automatic set_sync_pair(input logic [7:0] first_val, input logic [7:0] second_val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IDX_SYNC_FIRST;
        cfg_data  <= first_val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_IDX_SYNC_SECOND;
        cfg_data  <= second_val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tx_first  = first_val;
        tx_second = second_val;
        @(posedge aclk);
    endtask

    // Full frame; payload either random or alternating fill/inverted fill.
    // cut_at >= 0 stops after that many payload bytes (broken frame).
    task automatic send_frame(input logic [7:0] id, input int len, input bit rand_fill,
                              input logic [7:0] fill, input bit bad_lo, input bit bad_hi,
                              input bit dup_sync, input int cut_at);
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] pb;
        a = id;
        b = id;
        a = a + len[7:0];
        b = b + a;
        send_byte(tx_first);
        if (dup_sync && tx_first != tx_second) send_byte(tx_first);
        send_byte(tx_second);
        send_byte(id);
        send_byte(len[7:0]);
        for (int i = 0; i < len; i++) begin
            if (cut_at >= 0 && i >= cut_at) return;
            pb = rand_fill ? 8'($urandom) : (i[0] ? ~fill : fill);
            a = a + pb;
            b = b + a;
            send_byte(pb);
        end
        if (cut_at >= 0) return;
        send_byte(bad_lo ? a ^ 8'($urandom_range(1, 255)) : a);
        send_byte(bad_hi ? b ^ 8'($urandom_range(1, 255)) : b);
    endtask

    // Mix of good frames, bad checks, repeated syncs, noise and cut frames
    task automatic random_traffic(input int n_bytes);
        int stop_at;
        int pick;
        int len;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(99);
            len  = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
            if (pick < 70) begin
                send_frame(8'($urandom), len, 1'b1, 8'h00, $urandom_range(15) == 0,
                           $urandom_range(15) == 0, 1'b0, -1);
            end else if (pick < 80) begin
                send_frame(8'($urandom), len, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1, -1);
            end else if (pick < 88) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end else if (pick < 93) begin
                // first sync followed by a wrong byte
                send_byte(tx_first);
                send_byte(8'($urandom));
            end else begin
                send_frame(8'($urandom), len + 1, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0,
                           $urandom_range(0, len));
            end
        end
    endtask

    // Directed frames under the default sync values
    task automatic test_directed();
        // zero-length frame, good check
        send_frame(8'hFF, 0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, -1);
        // repeated first sync, payload 00/FF, bad high check byte
        send_frame(8'h00, 2, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1, -1);
        // wrong second byte returns to hunt; the later second sync is ignored
        send_byte(tx_first);
        send_byte(8'h55);
        send_byte(tx_second);
        // bad low check byte on a zero-length frame
        send_frame(8'h12, 0, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, -1);
    endtask

    // Several sync settings, extremes and equal values among them
    task automatic test_sync_config();
        logic [7:0] firsts[5]  = '{8'h00, 8'hFF, 8'h5A, 8'h00, SYNC_FIRST_RESET};
        logic [7:0] seconds[5] = '{8'hFF, 8'h00, 8'h5A, 8'h00, SYNC_SECOND_RESET};
        for (int k = 0; k < 5; k++) begin
            set_sync_pair(firsts[k], seconds[k]);
            send_frame(8'($urandom), 3, 1'b1, 8'h00, 1'b0, 1'b0, 1'b1, -1);
            random_traffic(30);
        end
    endtask

    // Long random run over the three back-pressure modes
    task automatic test_random_stream();
        send_frame(8'($urandom), 255, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0, -1);
        random_traffic(150);
        tx_idle_pct = 78;
        rx_idle_pct = 21;
        random_traffic(325);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_traffic(325);
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_IDX_SYNC_FIRST;
        cfg_data  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        tx_idle_pct = 21;
        rx_idle_pct = 78;

        test_directed();
        test_sync_config();
        test_random_stream();
        wait_idle();

        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sync_packet_deframer_fletcher8_core.f
+incdir+rtl/core
rtl/core/spdf_pkg.sv
rtl/core/spdf_in_stage.sv
rtl/core/spdf_frame_fsm.sv
rtl/core/spdf_out_stage.sv
rtl/core/sync_packet_deframer_fletcher8_core.sv
bench/testbench.sv
